// ===== sv/vvga_pkg.sv =====
// Shared types, codes and constants of the voxel view gain accumulator.
// Used by vvga_ctrl, vvga_dp and voxel_view_gain_accumulator. No dependencies.
`timescale 1ns / 1ps

package vvga_pkg;

    // Stream widths
    localparam int InWidth   = 280;   // 274 payload bits padded to whole bytes
    localparam int OutWidth  = 80;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;

    // Iteration counts of the shared units
    localparam int SqrtSteps   = 32;
    localparam int CordicSteps = 30;
    localparam int DivSteps    = 32;
    localparam int StepW       = 5;

    // Fixed point constants
    localparam logic [31:0] OneQ16   = 32'h0001_0000;
    localparam logic [47:0] AccMax   = 48'hFFFF_FFFF_FFFF;
    localparam logic [32:0] OneQ32   = 33'h1_0000_0000;

    // Map states
    localparam logic [1:0] MapFree     = 2'd0;
    localparam logic [1:0] MapOccupied = 2'd1;
    localparam logic [1:0] MapUnknown  = 2'd2;

    // Discount modes
    localparam logic [1:0] ModeNone   = 2'd0;
    localparam logic [1:0] ModeLinear = 2'd1;
    localparam logic [1:0] ModeWeight = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgMode     = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgMinImp   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgNewVal   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgScale    = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgEdge     = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgAngHoriz = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgAngVert  = 3'd6;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ0,
        OP_SQ1,
        OP_SQ2,
        OP_SQE,
        OP_SQRT,
        OP_CINIT,
        OP_CORD,
        OP_DIVT,
        OP_DIVSTEP,
        OP_T2,
        OP_RA,
        OP_WLO,
        OP_WHI,
        OP_WEND,
        OP_DIVR,
        OP_DIVM,
        OP_DIVL,
        OP_ONE,
        OP_PV,
        OP_PLO,
        OP_PHI,
        OP_PEND,
        OP_GAIN,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [StepW-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic       occupied;
        logic [1:0] mode;
    } dp_stat_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [31:0] atan_entry(input logic [StepW-1:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'sd843314856;
            5'd1:  r = 32'sd497837829;
            5'd2:  r = 32'sd263043836;
            5'd3:  r = 32'sd133525158;
            5'd4:  r = 32'sd67021686;
            5'd5:  r = 32'sd33543515;
            5'd6:  r = 32'sd16775850;
            5'd7:  r = 32'sd8388437;
            5'd8:  r = 32'sd4194282;
            5'd9:  r = 32'sd2097149;
            5'd10: r = 32'sd1048575;
            5'd11: r = 32'sd524287;
            5'd12: r = 32'sd262143;
            5'd13: r = 32'sd131071;
            5'd14: r = 32'sd65535;
            5'd15: r = 32'sd32767;
            5'd16: r = 32'sd16383;
            5'd17: r = 32'sd8191;
            5'd18: r = 32'sd4095;
            5'd19: r = 32'sd2047;
            5'd20: r = 32'sd1023;
            5'd21: r = 32'sd511;
            5'd22: r = 32'sd255;
            5'd23: r = 32'sd127;
            5'd24: r = 32'sd63;
            5'd25: r = 32'sd31;
            5'd26: r = 32'sd15;
            5'd27: r = 32'sd7;
            5'd28: r = 32'sd3;
            5'd29: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/vvga_ctrl.sv =====
// Controller of the voxel view gain accumulator: sequences the datapath.
// Depends on vvga_pkg.
`timescale 1ns / 1ps

module vvga_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  vvga_pkg::dp_stat_t stat,
    output vvga_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_SQ0, S_SQ1, S_SQ2, S_SQE, S_SQRT, S_CINIT, S_CORD,
        S_DIVT, S_DIVTS, S_T2, S_RA, S_WLO, S_WHI, S_WEND, S_DIVR, S_DIVRS,
        S_DIVM, S_DIVMS, S_DIVL, S_DIVLS, S_ONE, S_PV, S_PLO, S_PHI, S_PEND,
        S_GAIN, S_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [vvga_pkg::StepW-1:0]   cnt_reg, cnt_next;
    logic                         ready_reg, ready_next;
    logic                         mvalid_reg, mvalid_next;

    assign s_tready = ready_reg;
    assign m_tvalid = mvalid_reg;

    // next state, step count and command
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd.op      = vvga_pkg::OP_NONE;
        cmd.step    = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.op     = vvga_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cnt_next = '0;
                if (!stat.occupied) begin
                    state_next = S_GAIN;
                end else if (stat.mode == vvga_pkg::ModeLinear) begin
                    state_next = S_DIVL;
                end else if (stat.mode == vvga_pkg::ModeWeight) begin
                    state_next = S_SQ0;
                end else begin
                    state_next = S_ONE;
                end
            end
            S_SQ0: begin cmd.op = vvga_pkg::OP_SQ0; state_next = S_SQ1; end
            S_SQ1: begin cmd.op = vvga_pkg::OP_SQ1; state_next = S_SQ2; end
            S_SQ2: begin cmd.op = vvga_pkg::OP_SQ2; state_next = S_SQE; end
            S_SQE: begin cmd.op = vvga_pkg::OP_SQE; state_next = S_SQRT; end
            S_SQRT: begin
                cmd.op   = vvga_pkg::OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == vvga_pkg::StepW'(vvga_pkg::SqrtSteps - 1)) begin
                    cnt_next   = '0;
                    state_next = S_CINIT;
                end
            end
            S_CINIT: begin cmd.op = vvga_pkg::OP_CINIT; state_next = S_CORD; end
            S_CORD: begin
                cmd.op   = vvga_pkg::OP_CORD;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == vvga_pkg::StepW'(vvga_pkg::CordicSteps - 1)) begin
                    cnt_next   = '0;
                    state_next = S_DIVT;
                end
            end
            S_DIVT: begin cmd.op = vvga_pkg::OP_DIVT; state_next = S_DIVTS; end
            S_DIVTS, S_DIVRS, S_DIVMS, S_DIVLS: begin
                cmd.op   = vvga_pkg::OP_DIVSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == vvga_pkg::StepW'(vvga_pkg::DivSteps - 1)) begin
                    cnt_next = '0;
                    case (state_reg)
                        S_DIVTS: state_next = S_T2;
                        S_DIVRS: state_next = S_DIVM;
                        default: state_next = S_PV;
                    endcase
                end
            end
            S_T2:   begin cmd.op = vvga_pkg::OP_T2;   state_next = S_RA;   end
            S_RA:   begin cmd.op = vvga_pkg::OP_RA;   state_next = S_WLO;  end
            S_WLO:  begin cmd.op = vvga_pkg::OP_WLO;  state_next = S_WHI;  end
            S_WHI:  begin cmd.op = vvga_pkg::OP_WHI;  state_next = S_WEND; end
            S_WEND: begin cmd.op = vvga_pkg::OP_WEND; state_next = S_DIVR; end
            S_DIVR: begin cmd.op = vvga_pkg::OP_DIVR; state_next = S_DIVRS; end
            S_DIVM: begin cmd.op = vvga_pkg::OP_DIVM; state_next = S_DIVMS; end
            S_DIVL: begin cmd.op = vvga_pkg::OP_DIVL; state_next = S_DIVLS; end
            S_ONE:  begin cmd.op = vvga_pkg::OP_ONE;  state_next = S_PV;   end
            S_PV:   begin cmd.op = vvga_pkg::OP_PV;   state_next = S_PLO;  end
            S_PLO:  begin cmd.op = vvga_pkg::OP_PLO;  state_next = S_PHI;  end
            S_PHI:  begin cmd.op = vvga_pkg::OP_PHI;  state_next = S_PEND; end
            S_PEND: begin cmd.op = vvga_pkg::OP_PEND; state_next = S_GAIN; end
            S_GAIN: begin cmd.op = vvga_pkg::OP_GAIN; state_next = S_EMIT; end
            S_EMIT: begin
                // hand the result over once the output register is free
                if (!mvalid_reg || m_tready) begin
                    cmd.op      = vvga_pkg::OP_EMIT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ready_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ready_reg  <= ready_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ===== sv/vvga_dp.sv =====
// Datapath of the voxel view gain accumulator: config registers, shared
// multiplier, square root, CORDIC and divider units, accumulator. Uses vvga_pkg.
`timescale 1ns / 1ps

module vvga_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vvga_pkg::dp_cmd_t                   cmd,
    output vvga_pkg::dp_stat_t                  stat,
    input  logic [vvga_pkg::InWidth-1:0]        s_tdata,
    input  logic                                s_tlast,
    input  logic                                cfg_valid,
    input  logic [vvga_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [vvga_pkg::CfgDataW-1:0]       cfg_data,
    output logic [vvga_pkg::OutWidth-1:0]       m_tdata,
    output logic                                m_tlast
);

    // configuration registers
    logic [1:0]  mode_reg;
    logic [15:0] mimp_reg;
    logic [31:0] nvv_reg, scale_reg, edge_reg, rah_reg, rav_reg;

    // item registers
    logic [30:0] mag_reg [3];
    logic [1:0]  mstate_reg;
    logic [15:0] cnt_reg;
    logic [31:0] wgt_reg, val_reg;
    logic        last_reg;

    // working registers
    logic [63:0]        mul_reg, sq_reg, a_reg, p_reg;
    logic [34:0]        rem_reg;
    logic [31:0]        root_reg, z_reg;
    logic signed [63:0] x_reg, y_reg;
    logic signed [31:0] ang_reg;
    logic [97:0]        num_reg, den_reg;
    logic [32:0]        q_reg;
    logic               hold_reg;
    logic [83:0]        n_reg;
    logic [95:0]        pw_reg;
    logic [96:0]        pr_reg;
    logic [31:0]        gain_reg, ogain_reg;
    logic [47:0]        tot_reg, acc_reg, otot_reg;
    logic               done_reg, olast_reg;

    logic [31:0] mul_a, mul_b;
    logic [97:0] init_num, init_den;
    logic        init_zero;

    logic [31:0] gain_w;
    logic [48:0] sum_w;
    logic [47:0] acc_next_w;

    assign stat.occupied = (mstate_reg == vvga_pkg::MapOccupied);
    assign stat.mode     = mode_reg;
    assign m_tdata       = {otot_reg, ogain_reg};
    assign m_tlast       = olast_reg;

    // |a - b| of two signed Q16.16 values, held below 2^31
    function automatic logic [30:0] axis_mag(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        m = d[32] ? 33'(-d) : 33'(d);
        return (m > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
    endfunction

    // shared 32x32 multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            vvga_pkg::OP_SQ0: begin mul_a = {1'b0, mag_reg[0]}; mul_b = {1'b0, mag_reg[0]}; end
            vvga_pkg::OP_SQ1: begin mul_a = {1'b0, mag_reg[1]}; mul_b = {1'b0, mag_reg[1]}; end
            vvga_pkg::OP_SQ2: begin mul_a = {1'b0, mag_reg[2]}; mul_b = {1'b0, mag_reg[2]}; end
            vvga_pkg::OP_T2:  begin mul_a = q_reg[31:0]; mul_b = q_reg[31:0]; end
            vvga_pkg::OP_RA:  begin mul_a = rah_reg; mul_b = rav_reg; end
            vvga_pkg::OP_WLO: begin mul_a = wgt_reg; mul_b = mul_reg[31:0]; end
            vvga_pkg::OP_WHI: begin mul_a = wgt_reg; mul_b = a_reg[63:32]; end
            vvga_pkg::OP_PV:  begin mul_a = scale_reg; mul_b = val_reg; end
            vvga_pkg::OP_PLO: begin mul_a = mul_reg[31:0]; mul_b = q_reg[31:0]; end
            vvga_pkg::OP_PHI: begin mul_a = p_reg[63:32]; mul_b = q_reg[31:0]; end
            default: ;
        endcase
    end

    // divider start values
    always_comb begin
        init_num  = '0;
        init_den  = '0;
        init_zero = 1'b0;
        case (cmd.op)
            vvga_pkg::OP_DIVT: begin
                // t = s * 2^16 / z with s = 2 * max(angle, 0)
                init_num = ang_reg[31] ? 98'd0 : {66'd0, ang_reg[30:0], 1'b0};
                init_den = {50'd0, z_reg, 16'd0};
            end
            vvga_pkg::OP_DIVR: begin
                init_num = {14'd0, n_reg};
                init_den = 98'({14'd0, n_reg} + {2'd0, pw_reg});
            end
            vvga_pkg::OP_DIVM: begin
                // rescale above the minimum impact, zero at or below it
                init_zero = (q_reg <= {1'b0, mimp_reg, 16'd0});
                init_num  = {65'd0, 33'(q_reg - {1'b0, mimp_reg, 16'd0})};
                init_den  = {65'd0, 33'(vvga_pkg::OneQ32 - {1'b0, mimp_reg, 16'd0})};
            end
            vvga_pkg::OP_DIVL: begin
                init_num = 98'd1;
                init_den = {81'd0, 17'({1'b0, cnt_reg} + 17'd1)};
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= vvga_pkg::ModeWeight;
            mimp_reg  <= 16'd0;
            nvv_reg   <= 32'd32768;
            scale_reg <= 32'd65536;
            edge_reg  <= 32'd6554;
            rah_reg   <= 32'd10737418;
            rav_reg   <= 32'd10737418;
        end else if (cfg_valid) begin
            case (cfg_index)
                vvga_pkg::CfgMode:     mode_reg  <= cfg_data[1:0];
                vvga_pkg::CfgMinImp:   mimp_reg  <= cfg_data[15:0];
                vvga_pkg::CfgNewVal:   nvv_reg   <= cfg_data;
                vvga_pkg::CfgScale:    scale_reg <= cfg_data;
                vvga_pkg::CfgEdge:     edge_reg  <= cfg_data;
                vvga_pkg::CfgAngHoriz: rah_reg   <= cfg_data;
                vvga_pkg::CfgAngVert:  rav_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // gain accumulator and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.op == vvga_pkg::OP_GAIN) begin
            acc_reg <= last_reg ? 48'd0 : acc_next_w;
        end
    end

    always_comb begin
        case (mstate_reg)
            vvga_pkg::MapOccupied:
                gain_w = (pr_reg[96:80] != 17'd0) ? 32'hFFFF_FFFF : pr_reg[79:48];
            vvga_pkg::MapUnknown: gain_w = nvv_reg;
            default:              gain_w = 32'd0;
        endcase
        sum_w      = {1'b0, acc_reg} + {17'd0, gain_w};
        acc_next_w = sum_w[48] ? vvga_pkg::AccMax : sum_w[47:0];
    end

    // working datapath
    always_ff @(posedge aclk) begin
        logic [34:0]        rem_t, trial;
        logic signed [63:0] dx, dy;
        logic [97:0]        num_sh;
        logic [31:0]        zv;
        mul_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        case (cmd.op)
            vvga_pkg::OP_LOAD: begin
                mag_reg[0] <= axis_mag(s_tdata[31:0],  s_tdata[127:96]);
                mag_reg[1] <= axis_mag(s_tdata[63:32], s_tdata[159:128]);
                mag_reg[2] <= axis_mag(s_tdata[95:64], s_tdata[191:160]);
                mstate_reg <= s_tdata[193:192];
                cnt_reg    <= s_tdata[209:194];
                wgt_reg    <= s_tdata[241:210];
                val_reg    <= s_tdata[273:242];
                last_reg   <= s_tlast;
            end
            vvga_pkg::OP_SQ1: sq_reg <= mul_reg;
            vvga_pkg::OP_SQ2: sq_reg <= sq_reg + mul_reg;
            vvga_pkg::OP_SQE: begin
                sq_reg   <= sq_reg + mul_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            vvga_pkg::OP_SQRT: begin
                // one root bit per step
                rem_t = {rem_reg[32:0], sq_reg[63:62]};
                trial = {1'b0, root_reg, 2'b01};
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                sq_reg <= {sq_reg[61:0], 2'b00};
            end
            vvga_pkg::OP_CINIT: begin
                zv      = (root_reg < vvga_pkg::OneQ16) ? vvga_pkg::OneQ16 : root_reg;
                z_reg   <= zv;
                x_reg   <= $signed({7'd0, zv, 25'd0});
                y_reg   <= $signed({8'd0, edge_reg, 24'd0});
                ang_reg <= '0;
            end
            vvga_pkg::OP_CORD: begin
                // vectoring rotation towards the x axis
                dx = y_reg >>> cmd.step;
                dy = x_reg >>> cmd.step;
                if (y_reg > 0) begin
                    x_reg   <= x_reg + dx;
                    y_reg   <= y_reg - dy;
                    ang_reg <= ang_reg + vvga_pkg::atan_entry(cmd.step);
                end else if (y_reg < 0) begin
                    x_reg   <= x_reg - dx;
                    y_reg   <= y_reg + dy;
                    ang_reg <= ang_reg - vvga_pkg::atan_entry(cmd.step);
                end
            end
            vvga_pkg::OP_DIVT, vvga_pkg::OP_DIVR, vvga_pkg::OP_DIVM,
            vvga_pkg::OP_DIVL: begin
                num_reg <= init_num;
                den_reg <= init_den;
                if (init_zero || init_den == 98'd0) begin
                    q_reg    <= '0;
                    hold_reg <= 1'b1;
                end else if (init_num >= init_den) begin
                    q_reg    <= vvga_pkg::OneQ32;
                    hold_reg <= 1'b1;
                end else begin
                    q_reg    <= '0;
                    hold_reg <= 1'b0;
                end
            end
            vvga_pkg::OP_DIVSTEP: begin
                // restoring division, one quotient bit per step
                if (!hold_reg) begin
                    num_sh = {num_reg[96:0], 1'b0};
                    if (num_sh >= den_reg) begin
                        num_reg <= num_sh - den_reg;
                        q_reg   <= {q_reg[31:0], 1'b1};
                    end else begin
                        num_reg <= num_sh;
                        q_reg   <= {q_reg[31:0], 1'b0};
                    end
                end
            end
            vvga_pkg::OP_RA:   n_reg  <= {mul_reg, 20'd0};
            vvga_pkg::OP_WLO:  a_reg  <= mul_reg;
            vvga_pkg::OP_WHI:  pw_reg <= {32'd0, mul_reg};
            vvga_pkg::OP_WEND: pw_reg <= pw_reg + {mul_reg, 32'd0};
            vvga_pkg::OP_ONE:  q_reg  <= vvga_pkg::OneQ32;
            vvga_pkg::OP_PLO:  p_reg  <= mul_reg;
            vvga_pkg::OP_PHI:  pr_reg <= {33'd0, mul_reg};
            vvga_pkg::OP_PEND: begin
                // a discount of exactly one bypasses the partial products
                if (q_reg[32]) pr_reg <= {1'b0, p_reg, 32'd0};
                else           pr_reg <= 97'(pr_reg + {1'b0, mul_reg, 32'd0});
            end
            vvga_pkg::OP_GAIN: begin
                gain_reg <= gain_w;
                tot_reg  <= acc_next_w;
                done_reg <= last_reg;
            end
            vvga_pkg::OP_EMIT: begin
                ogain_reg <= gain_reg;
                otot_reg  <= tot_reg;
                olast_reg <= done_reg;
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/voxel_view_gain_accumulator.sv =====
// Top level of the voxel view gain accumulator: controller plus datapath.
// Depends on vvga_pkg, vvga_ctrl and vvga_dp.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata (280), s_tlast = last_voxel
//  m_      | out       | m_tvalid/m_tready  | m_tdata (80), m_tlast = sum_done
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index (3), cfg_data (32)
//
// One word at a time. Free and unknown voxels go straight to the gain step; occupied
// voxels first take the path of their discount mode: no discount, linear discount
// (32-step divider) or the weight ratio (32-step root, 30-step CORDIC, three
// 32-step divisions on one divider). m_tvalid rises and the next word can be taken once
// the result moves to the output register. A waiting result sits in the output register;
// the next word is accepted while it waits. Reset is synchronous.
`timescale 1ns / 1ps

module voxel_view_gain_accumulator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // voxel_x, voxel_y, voxel_z, origin_x, origin_y, origin_z, map_state,
    // observed_count, map_weight, map_value, zero pad
    input  logic [vvga_pkg::InWidth-1:0]      s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // voxel_gain, gain_total
    output logic [vvga_pkg::OutWidth-1:0]     m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vvga_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [vvga_pkg::CfgDataW-1:0]     cfg_data
);

    vvga_pkg::dp_cmd_t  cmd;
    vvga_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    vvga_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vvga_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // an accepted word keeps the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // the running total always covers the voxel's own gain
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[79:32] >= {16'd0, m_tdata[31:0]}))
        else $error("gain total below voxel gain");

    // a new result only appears after the block has been working
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of voxel_view_gain_accumulator: directed and random voxel lists,
// register phases, random gaps on both streams. Depends on vvga_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import vvga_pkg::*;

    localparam int SettleCycles = 400;   // beyond the slowest occupied voxel

    typedef struct {
        logic signed [31:0] vx, vy, vz, ox, oy, oz;
        logic [1:0]         state;
        logic [15:0]        count;
        logic [31:0]        weight;
        logic [31:0]        value;
        logic               last;
    } voxel_t;

    typedef enum logic [1:0] { W_VOXEL, W_REG, W_DRAIN } work_kind_t;

    typedef struct {
        work_kind_t          kind;
        voxel_t              vox;
        logic [CfgIdxW-1:0]  idx;
        logic [CfgDataW-1:0] data;
    } work_t;

    typedef struct {
        logic [31:0] gain;
        logic [47:0] total;
        logic        done;
    } gain_word_t;

    // atan(2^-i), Q2.30 truncated
    localparam longint AtanQ30 [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [InWidth-1:0]    s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OutWidth-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CfgIdxW-1:0]    cfg_index = '0;
    logic [CfgDataW-1:0]   cfg_data = '0;

    work_t      pending_q[$];
    gain_word_t gain_exp_q[$];
    voxel_t     vox_on_bus;
    logic       s_hs = 1'b0, c_hs = 1'b0;
    logic       feed_done = 1'b0;
    int         quiet_cycles = 0;
    int         mismatches = 0;

    // shadow registers and running sum
    logic [1:0]  sh_mode;
    logic [15:0] sh_min_imp;
    logic [31:0] sh_new_val, sh_scale, sh_edge, sh_ang_h, sh_ang_v;
    logic [47:0] sum_acc;

    voxel_view_gain_accumulator DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------- prediction ----------------
    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] res, b;
        res = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // floor(2^32*num/den), one when num >= den, zero when den is zero
    function automatic logic [32:0] frac_q32(logic [127:0] num, logic [127:0] den);
        logic [159:0] q;
        if (den == 0) return '0;
        if (num >= den) return OneQ32;
        q = {num, 32'b0} / {32'b0, den};
        return q[32:0];
    endfunction

    function automatic logic [63:0] axis_sq(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        logic [63:0] m;
        d = longint'(a) - longint'(b);
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        return m * m;
    endfunction

    function automatic logic [32:0] weight_ratio_discount(voxel_t v);
        logic [63:0]  span, z, s, t, t2, area;
        longint       x, y, ang, dx, dy;
        logic [127:0] n, sum;
        logic [32:0]  ratio, m;
        span = floor_sqrt(axis_sq(v.vx, v.ox) + axis_sq(v.vy, v.oy) + axis_sq(v.vz, v.oz));
        z = (span < 64'd65536) ? 64'd65536 : span;
        x = longint'(z << 25);
        y = longint'({32'b0, sh_edge} << 24);
        ang = 0;
        // vectoring rotations towards the x axis
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; ang += AtanQ30[i];
            end else if (y < 0) begin
                x -= dx; y += dy; ang -= AtanQ30[i];
            end
        end
        if (ang < 0) ang = 0;
        s = 64'(ang) * 2;
        t = (s << 16) / z;
        t2 = t * t;
        n = {64'b0, t2} << 20;
        area = {32'b0, sh_ang_h} * {32'b0, sh_ang_v};
        sum = n + {96'b0, v.weight} * {64'b0, area};
        ratio = frac_q32(n, sum);
        m = {1'b0, sh_min_imp, 16'b0};
        if (ratio <= m) return '0;
        return frac_q32({95'b0, ratio - m}, {95'b0, OneQ32 - m});
    endfunction

    function automatic gain_word_t predict_gain(voxel_t v);
        gain_word_t   r;
        logic [32:0]  disc;
        logic [63:0]  pv, g, tot;
        logic [127:0] prod;
        g = '0;
        if (v.state == MapOccupied) begin
            disc = OneQ32;
            if (sh_mode == ModeLinear)
                disc = 33'(OneQ32 / ({17'b0, v.count} + 33'd1));
            else if (sh_mode == ModeWeight)
                disc = weight_ratio_discount(v);
            pv = {32'b0, sh_scale} * {32'b0, v.value};
            prod = {64'b0, pv} * {95'b0, disc};
            if (prod[127:96] != 0) g = 64'hFFFF_FFFF;
            else begin
                g = 64'(prod >> 48);
                if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
            end
        end else if (v.state == MapUnknown) begin
            g = {32'b0, sh_new_val};
        end
        tot = {16'b0, sum_acc} + g;
        if (tot > {16'b0, AccMax}) tot = {16'b0, AccMax};
        r.gain = g[31:0];
        r.total = tot[47:0];
        r.done = v.last;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic voxel_t rand_voxel(logic last);
        voxel_t v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            v.vx = $urandom; v.vy = $urandom; v.vz = $urandom;
            v.ox = $urandom; v.oy = $urandom; v.oz = $urandom;
        end else begin
            v.ox = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            v.oy = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            v.oz = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            // close voxels exercise the one-metre floor on the distance
            if (r < 30) begin
                v.vx = v.ox + $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
                v.vy = v.oy + $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
                v.vz = v.oz + $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
            end else begin
                v.vx = v.ox + $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
                v.vy = v.oy + $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
                v.vz = v.oz + $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            end
        end
        r = $urandom_range(0, 9);
        v.state = (r < 5) ? MapOccupied : (r < 7) ? MapUnknown : (r < 9) ? MapFree : 2'd3;
        r = $urandom_range(0, 9);
        v.count = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        r = $urandom_range(0, 9);
        v.weight = (r < 2) ? 32'd0 : (r < 6) ? $urandom_range(0, 32'h10_0000) : $urandom;
        r = $urandom_range(0, 9);
        v.value = (r < 3) ? $urandom_range(0, 32'h4_0000) : $urandom;
        v.last = last;
        return v;
    endfunction

    task automatic push_voxel(voxel_t v);
        work_t w;
        w.kind = W_VOXEL;
        w.vox = v;
        pending_q.insert(pending_q.size(), w);
    endtask

    task automatic push_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        work_t w;
        w.kind = W_REG;
        w.idx = idx;
        w.data = data;
        pending_q.insert(pending_q.size(), w);
    endtask

    task automatic push_list(int n);
        for (int k = 0; k < n; k++) push_voxel(rand_voxel(k == n - 1));
    endtask

    // ---------------- stimulus ----------------
    initial begin
        voxel_t v;
        work_t  w;
        int     left;
        // defaults: weight ratio mode; directed extremes
        v = rand_voxel(1'b0);
        v.vx = 32'sh7FFF_FFFF; v.vy = 32'sh7FFF_FFFF; v.vz = 32'sh7FFF_FFFF;
        v.ox = 32'sh8000_0000; v.oy = 32'sh8000_0000; v.oz = 32'sh8000_0000;
        v.state = MapOccupied; v.weight = 32'hFFFF_FFFF; v.value = 32'hFFFF_FFFF;
        push_voxel(v);
        v.vx = 0; v.vy = 0; v.vz = 0; v.ox = 0; v.oy = 0; v.oz = 0;
        v.weight = 0; push_voxel(v);                      // same point, zero weight
        v.weight = 32'h1; v.value = 32'h1_0000; push_voxel(v);
        v.vx = 32'sh8000_0000; v.ox = 32'sh7FFF_FFFF; push_voxel(v);
        v.state = MapUnknown; push_voxel(v);
        v.state = MapFree; push_voxel(v);
        v.state = 2'd3; v.count = 16'hFFFF; push_voxel(v);
        v.state = MapOccupied; v.value = 0; v.last = 1'b1; push_voxel(v);
        for (int p = 0; p < 9; p++) begin
            if (p > 0) begin
                case (p)
                    1: begin
                        push_reg(CfgMode, CfgDataW'(ModeNone));
                        push_reg(CfgMinImp, 32'd0);
                        push_reg(CfgNewVal, '1);        push_reg(CfgScale, '1);
                        push_reg(CfgEdge, '1);          push_reg(CfgAngHoriz, '1);
                        push_reg(CfgAngVert, '1);
                    end
                    2: begin
                        push_reg(CfgMode, CfgDataW'(ModeLinear));
                        push_reg(CfgMinImp, 32'hFFFF);
                        push_reg(CfgNewVal, 32'd0);     push_reg(CfgScale, 32'd0);
                        push_reg(CfgEdge, 32'd1);       push_reg(CfgAngHoriz, 32'd1);
                        push_reg(CfgAngVert, 32'd1);
                    end
                    3: begin
                        // zero edge and zero ray angles
                        push_reg(CfgMode, CfgDataW'(ModeWeight));
                        push_reg(CfgMinImp, 32'd0);
                        push_reg(CfgScale, 32'h1_0000); push_reg(CfgEdge, 32'd0);
                        push_reg(CfgAngHoriz, 32'd0);   push_reg(CfgAngVert, 32'd0);
                    end
                    4: begin
                        push_reg(CfgMode, CfgDataW'(2'd3));
                        push_reg(CfgEdge, 32'd6554);
                        push_reg(CfgAngHoriz, 32'd0);   push_reg(CfgAngVert, $urandom);
                    end
                    5: begin
                        push_reg(CfgMode, CfgDataW'(ModeWeight));
                        push_reg(CfgMinImp, 32'hFFFF);
                        push_reg(CfgEdge, $urandom);    push_reg(CfgAngHoriz, $urandom);
                        push_reg(CfgAngVert, $urandom);
                    end
                    default: begin
                        push_reg(CfgMode, CfgDataW'((p == 7) ? ModeLinear : ModeWeight));
                        push_reg(CfgMinImp, $urandom_range(0, 65535));
                        push_reg(CfgNewVal, $urandom);
                        push_reg(CfgScale, $urandom_range(0, 32'h40_0000));
                        push_reg(CfgEdge, $urandom_range(1, 32'h4_0000));
                        push_reg(CfgAngHoriz, $urandom_range(1, 32'h1000_0000));
                        push_reg(CfgAngVert, $urandom_range(1, 32'h1000_0000));
                    end
                endcase
            end
            left = 160;
            while (left > 0) begin
                int n;
                n = $urandom_range(1, 12);
                if (n > left) n = left;
                push_list(n);
                left -= n;
                if (left > 70 && left <= 70 + n) begin
                    // hold the sender until all results are back
                    w.kind = W_DRAIN;
                    pending_q.insert(pending_q.size(), w);
                end
            end
        end
    end

    // ---------------- reset ----------------
    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------- driver ----------------
    int gap = 0, burst = 0, m_stall = 0, m_burst = 0;

    always @(negedge aclk) begin
        logic s_live, c_live, nxt_sv, nxt_cv;
        int   r;
        s_live = s_tvalid && !s_hs;
        c_live = cfg_valid && !c_hs;
        nxt_sv = s_live;
        nxt_cv = c_live;
        if (aresetn && !s_live && !c_live) begin
            if (gap > 0) begin
                gap--;
            end else if (pending_q.size() != 0) begin
                case (pending_q[0].kind)
                    W_VOXEL: begin
                        vox_on_bus = pending_q[0].vox;
                        s_tdata <= {6'b0, vox_on_bus.value, vox_on_bus.weight,
                                    vox_on_bus.count, vox_on_bus.state,
                                    vox_on_bus.oz, vox_on_bus.oy, vox_on_bus.ox,
                                    vox_on_bus.vz, vox_on_bus.vy, vox_on_bus.vx};
                        s_tlast <= vox_on_bus.last;
                        nxt_sv = 1'b1;
                        void'(pending_q.pop_front());
                        if (burst > 0) burst--;
                        else begin
                            r = $urandom_range(0, 99);
                            if (r < 3) burst = $urandom_range(20, 60);
                            else if (r < 55) gap = 0;
                            else if (r < 92) gap = $urandom_range(1, 3);
                            else gap = $urandom_range(10, 40);
                        end
                    end
                    W_REG: begin
                        if (gain_exp_q.size() == 0 && quiet_cycles >= SettleCycles) begin
                            cfg_index <= pending_q[0].idx;
                            cfg_data <= pending_q[0].data;
                            nxt_cv = 1'b1;
                            void'(pending_q.pop_front());
                        end
                    end
                    default: begin
                        if (gain_exp_q.size() == 0) void'(pending_q.pop_front());
                    end
                endcase
            end else begin
                feed_done <= 1'b1;
            end
        end
        s_tvalid <= nxt_sv;
        cfg_valid <= nxt_cv;

        // result side back-pressure
        if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn;
            if (m_burst > 0) m_burst--;
            else begin
                r = $urandom_range(0, 99);
                if (r < 3) m_burst = $urandom_range(30, 100);
                else if (r < 25) m_stall = $urandom_range(1, 3);
                else if (r < 29) m_stall = $urandom_range(10, 40);
            end
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        gain_word_t e, got;
        s_hs <= s_tvalid && s_tready;
        c_hs <= cfg_valid && cfg_ready;
        if (!aresetn) begin
            sh_mode = ModeWeight;     sh_min_imp = 16'd0;
            sh_new_val = 32'd32768;   sh_scale = 32'd65536;
            sh_edge = 32'd6554;       sh_ang_h = 32'd10737418;
            sh_ang_v = 32'd10737418;  sum_acc = '0;
            quiet_cycles <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CfgMode:     sh_mode = cfg_data[1:0];
                    CfgMinImp:   sh_min_imp = cfg_data[15:0];
                    CfgNewVal:   sh_new_val = cfg_data;
                    CfgScale:    sh_scale = cfg_data;
                    CfgEdge:     sh_edge = cfg_data;
                    CfgAngHoriz: sh_ang_h = cfg_data;
                    CfgAngVert:  sh_ang_v = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                e = predict_gain(vox_on_bus);
                sum_acc = e.done ? 48'd0 : e.total;
                gain_exp_q.insert(gain_exp_q.size(), e);
            end
            if (m_tvalid && m_tready) begin
                got.gain = m_tdata[31:0];
                got.total = m_tdata[79:32];
                got.done = m_tlast;
                if (gain_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: gain %h total %h done %b",
                                 got.gain, got.total, got.done);
                end else begin
                    e = gain_exp_q.pop_front();
                    if (e.gain !== got.gain || e.total !== got.total || e.done !== got.done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: gain %h/%h total %h/%h done %b/%b (exp/got)",
                                     e.gain, got.gain, e.total, got.total, e.done, got.done);
                    end
                end
            end
            quiet_cycles <= (gain_exp_q.size() == 0 && !s_tvalid) ? quiet_cycles + 1 : 0;
        end
    end

    // ---------------- end of run ----------------
    initial begin
        @(posedge aresetn);
        while (!feed_done || gain_exp_q.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        if (gain_exp_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== voxel_view_gain_accumulator.f =====
sv/vvga_pkg.sv
sv/vvga_ctrl.sv
sv/vvga_dp.sv
sv/voxel_view_gain_accumulator.sv
tb/tb_top.sv
